// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LRA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("letterbox addresser assertion failed");

// Next-cycle implication, disabled while in reset.
`define LRA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("letterbox addresser assertion failed");

`endif

// ===== sv/lra_pkg.sv =====
// Types and codes for the letterbox resize addresser.
// No dependencies; used by every module of the block.
package lra_pkg;

  typedef enum logic [2:0] {
    REG_SRC_W     = 3'd0,
    REG_SRC_H     = 3'd1,
    REG_SRC_PITCH = 3'd2,
    REG_DST_W     = 3'd3,
    REG_DST_H     = 3'd4,
    REG_DST_PITCH = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    LAY_MUL,
    LAY_SEL,
    LAY_DIV,
    LAY_FIN,
    LAY_DONE
  } lay_state_e;

  localparam logic [13:0] RST_SRC_W     = 14'd1920;
  localparam logic [13:0] RST_SRC_H     = 14'd1080;
  localparam logic [15:0] RST_SRC_PITCH = 16'd7680;
  localparam logic [13:0] RST_DST_W     = 14'd640;
  localparam logic [13:0] RST_DST_H     = 14'd640;
  localparam logic [15:0] RST_DST_PITCH = 16'd2560;

  localparam int unsigned QBITS = 14;  // quotient bits of the per-pixel divide

  typedef struct packed {
    logic [12:0] out_col;
    logic [12:0] out_row;
  } in_t;

  typedef struct packed {
    logic        config_error;
    logic        is_padding;
    logic [12:0] src_col;
    logic [12:0] src_row;
    logic [28:0] src_byte_offset;
    logic [28:0] dst_byte_offset;
    logic [13:0] fit_width;
    logic [13:0] fit_height;
    logic [12:0] margin_left;
    logic [12:0] pad_top;
  } out_t;

  // Layout for front/back; the user keeps it stable while items are in flight.
  typedef struct packed {
    logic        ready;
    logic        err;
    logic [13:0] sw;
    logic [13:0] sh;
    logic [15:0] spitch;
    logic [15:0] tpitch;
    logic [13:0] scw;
    logic [13:0] sch;
    logic [12:0] pl;
    logic [12:0] pt;
  } lay_t;

  typedef struct packed {
    logic        pad;
    logic [26:0] ncol;
    logic [26:0] nrow;
    logic [28:0] doff;
  } q_item_t;

  typedef struct packed {
    logic        pad;
    logic [26:0] rcol;
    logic [26:0] rrow;
    logic [13:0] qcol;
    logic [13:0] qrow;
    logic [28:0] doff;
  } div_t;

endpackage

// ===== sv/lra_layout.sv =====
// Configuration registers and the letterbox layout solver.
// Uses lra_pkg; writes rerun a shift-subtract divider, skipped on error.
module lra_layout #(
  parameter int unsigned MAX_DIM = 8192
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  output lra_pkg::lay_t      lay_o
);

  logic [13:0] sw_q, sh_q, tw_q, th_q;
  logic [15:0] spitch_q, tpitch_q;

  lra_pkg::lay_state_e state_q, state_d;

  logic [27:0] p1_q, p2_q;
  logic        err_q, wide_q;
  logic [28:0] num_q;
  logic [13:0] rem_q;
  logic [13:0] den_q;
  logic [4:0]  cnt_q;
  logic [13:0] scw_q, sch_q;
  logic [12:0] pl_q, pt_q;

  logic        sel_wide;
  logic [14:0] rem_sh;
  logic        rem_ge;
  logic [13:0] lim, clampv, scw_n, sch_n;
  logic        err_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q     <= lra_pkg::RST_SRC_W;
      sh_q     <= lra_pkg::RST_SRC_H;
      spitch_q <= lra_pkg::RST_SRC_PITCH;
      tw_q     <= lra_pkg::RST_DST_W;
      th_q     <= lra_pkg::RST_DST_H;
      tpitch_q <= lra_pkg::RST_DST_PITCH;
    end else if (cfg_we_i) begin
      unique case (lra_pkg::cfg_reg_e'(cfg_idx_i))
        lra_pkg::REG_SRC_W:     sw_q     <= cfg_data_i[13:0];
        lra_pkg::REG_SRC_H:     sh_q     <= cfg_data_i[13:0];
        lra_pkg::REG_SRC_PITCH: spitch_q <= cfg_data_i;
        lra_pkg::REG_DST_W:     tw_q     <= cfg_data_i[13:0];
        lra_pkg::REG_DST_H:     th_q     <= cfg_data_i[13:0];
        lra_pkg::REG_DST_PITCH: tpitch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign err_n = (sw_q == 14'd0) || (sh_q == 14'd0) || (tw_q == 14'd0) || (th_q == 14'd0) ||
                 ({3'b0, sw_q} > 17'(MAX_DIM)) || ({3'b0, sh_q} > 17'(MAX_DIM)) ||
                 ({3'b0, tw_q} > 17'(MAX_DIM)) || ({3'b0, th_q} > 17'(MAX_DIM)) ||
                 (spitch_q < {sw_q, 2'b00}) || (tpitch_q < {tw_q, 2'b00});

  assign sel_wide = (p1_q <= p2_q);
  assign rem_sh   = {rem_q, num_q[28]};
  assign rem_ge   = (rem_sh >= {1'b0, den_q});

  // Clamp the rounded ratio to 1..limit.
  always_comb begin
    lim = wide_q ? th_q : tw_q;
    if (num_q == 29'd0) begin
      clampv = 14'd1;
    end else if (num_q > {15'b0, lim}) begin
      clampv = lim;
    end else begin
      clampv = num_q[13:0];
    end
    scw_n = wide_q ? tw_q : clampv;
    sch_n = wide_q ? clampv : th_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lra_pkg::LAY_MUL;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lra_pkg::LAY_MUL:  state_d = lra_pkg::LAY_SEL;
      lra_pkg::LAY_SEL:  state_d = err_q ? lra_pkg::LAY_FIN : lra_pkg::LAY_DIV;
      lra_pkg::LAY_DIV:  state_d = (cnt_q == 5'd0) ? lra_pkg::LAY_FIN : lra_pkg::LAY_DIV;
      lra_pkg::LAY_FIN:  state_d = lra_pkg::LAY_DONE;
      lra_pkg::LAY_DONE: state_d = lra_pkg::LAY_DONE;
      default:           state_d = lra_pkg::LAY_MUL;
    endcase
    // any write restarts the solve from the new registers
    if (cfg_we_i) begin
      state_d = lra_pkg::LAY_MUL;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lra_pkg::LAY_MUL: begin
        p1_q  <= tw_q * sh_q;
        p2_q  <= th_q * sw_q;
        err_q <= err_n;
      end
      lra_pkg::LAY_SEL: begin
        wide_q <= sel_wide;
        den_q  <= sel_wide ? sw_q : sh_q;
        num_q  <= sel_wide ? ({1'b0, p1_q} + 29'(sw_q[13:1]))
                           : ({1'b0, p2_q} + 29'(sh_q[13:1]));
        rem_q  <= 14'd0;
        cnt_q  <= 5'd28;
      end
      lra_pkg::LAY_DIV: begin
        if (rem_ge) begin
          rem_q <= 14'(rem_sh - {1'b0, den_q});
        end else begin
          rem_q <= rem_sh[13:0];
        end
        num_q <= {num_q[27:0], rem_ge};
        cnt_q <= cnt_q - 5'd1;
      end
      lra_pkg::LAY_FIN: begin
        scw_q <= scw_n;
        sch_q <= sch_n;
        pl_q  <= 13'((tw_q - scw_n) >> 1);
        pt_q  <= 13'((th_q - sch_n) >> 1);
      end
      default: ;
    endcase
  end

  always_comb begin
    lay_o.ready  = (state_q == lra_pkg::LAY_DONE);
    lay_o.err    = err_q;
    lay_o.sw     = sw_q;
    lay_o.sh     = sh_q;
    lay_o.spitch = spitch_q;
    lay_o.tpitch = tpitch_q;
    lay_o.scw    = scw_q;
    lay_o.sch    = sch_q;
    lay_o.pl     = pl_q;
    lay_o.pt     = pt_q;
  end

endmodule

// ===== sv/lra_front.sv =====
// Front end: accepts pixel coordinates, marks padding, forms dividends.
// Uses lra_pkg; feeds lra_fifo.
module lra_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  lra_pkg::in_t     item_i,
  input  lra_pkg::lay_t    lay_i,
  input  logic             q_full_i,
  output logic             busy_o,
  output logic             push_o,
  output lra_pkg::q_item_t item_o
);

  logic        v1_q, v2_q;
  logic        advance, accept;
  logic [12:0] col1_q, row1_q, dcol1_q, drow1_q;
  logic        pad1_q;
  logic        pad_n;
  lra_pkg::q_item_t it2_q;

  assign advance = !(v2_q && q_full_i);
  assign busy_o  = !lay_i.ready || !advance;
  assign accept  = start_i && !busy_o;

  assign pad_n = (item_i.out_col < lay_i.pl) ||
                 ({2'b0, item_i.out_col} >= ({2'b0, lay_i.pl} + {1'b0, lay_i.scw})) ||
                 (item_i.out_row < lay_i.pt) ||
                 ({2'b0, item_i.out_row} >= ({2'b0, lay_i.pt} + {1'b0, lay_i.sch}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (advance) begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      col1_q  <= item_i.out_col;
      row1_q  <= item_i.out_row;
      pad1_q  <= pad_n;
      dcol1_q <= item_i.out_col - lay_i.pl;
      drow1_q <= item_i.out_row - lay_i.pt;
      // zero dividend on padding so the quotient comes out zero
      it2_q.pad  <= pad1_q;
      it2_q.ncol <= pad1_q ? 27'd0 : 27'(dcol1_q * lay_i.sw);
      it2_q.nrow <= pad1_q ? 27'd0 : 27'(drow1_q * lay_i.sh);
      it2_q.doff <= 29'(row1_q * lay_i.tpitch) + 29'({col1_q, 2'b00});
    end
  end

  assign push_o = v2_q && !q_full_i;
  assign item_o = it2_q;

endmodule

// ===== sv/lra_fifo.sv =====
// Two-word queue between the front end and the divide pipeline.
// Uses lra_pkg for the word type.
module lra_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lra_pkg::q_item_t wdata_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output lra_pkg::q_item_t rdata_o
);

  lra_pkg::q_item_t mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== sv/lra_back.sv =====
// Back end: restoring divide pipeline, byte offsets and the result register.
// Uses lra_pkg; pops lra_fifo each cycle it is not empty, never stalls.
module lra_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  lra_pkg::q_item_t item_i,
  input  lra_pkg::lay_t    lay_i,
  output logic             done_o,
  output lra_pkg::out_t    res_o
);

  localparam int unsigned NS = lra_pkg::QBITS;

  lra_pkg::div_t st_q [NS+1];
  logic [NS:0]   vld_q;

  logic          vo_q, done_q;
  logic          pado_q;
  logic [13:0]   qcol_q, qrow_q;
  logic [28:0]   soff_q, doff_q;
  lra_pkg::out_t res_q;

  function automatic lra_pkg::div_t div_step(lra_pkg::div_t s, logic [13:0] dc,
                                             logic [13:0] dr, logic [3:0] b);
    lra_pkg::div_t r;
    logic [27:0]   tc, tr;
    r  = s;
    tc = {14'b0, dc} << b;
    tr = {14'b0, dr} << b;
    if ({1'b0, s.rcol} >= tc) begin
      r.rcol    = 27'({1'b0, s.rcol} - tc);
      r.qcol[b] = 1'b1;
    end
    if ({1'b0, s.rrow} >= tr) begin
      r.rrow    = 27'({1'b0, s.rrow} - tr);
      r.qrow[b] = 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vo_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[NS-1:0], vld_i};
      vo_q   <= vld_q[NS];
      done_q <= vo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0].pad  <= item_i.pad;
    st_q[0].rcol <= item_i.ncol;
    st_q[0].rrow <= item_i.nrow;
    st_q[0].qcol <= '0;
    st_q[0].qrow <= '0;
    st_q[0].doff <= item_i.doff;
    // stage k settles quotient bit NS-1-k
    for (int k = 0; k < NS; k++) begin
      st_q[k+1] <= div_step(st_q[k], lay_i.scw, lay_i.sch, 4'(NS - 1 - k));
    end
  end

  always_ff @(posedge clk_i) begin
    pado_q <= st_q[NS].pad;
    qcol_q <= st_q[NS].qcol;
    qrow_q <= st_q[NS].qrow;
    doff_q <= st_q[NS].doff;
    soff_q <= 29'(st_q[NS].qrow * lay_i.spitch) + 29'({st_q[NS].qcol, 2'b00});
  end

  always_ff @(posedge clk_i) begin
    if (lay_i.err) begin
      res_q <= {1'b1, {($bits(lra_pkg::out_t) - 1){1'b0}}};
    end else begin
      res_q.config_error    <= 1'b0;
      res_q.is_padding      <= pado_q;
      res_q.src_col         <= pado_q ? 13'd0 : qcol_q[12:0];
      res_q.src_row         <= pado_q ? 13'd0 : qrow_q[12:0];
      res_q.src_byte_offset <= pado_q ? 29'd0 : soff_q;
      res_q.dst_byte_offset <= doff_q;
      res_q.fit_width       <= lay_i.scw;
      res_q.fit_height      <= lay_i.sch;
      res_q.margin_left     <= lay_i.pl;
      res_q.pad_top         <= lay_i.pt;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== sv/letterbox_resize_addresser.sv =====
// Letterbox resize addresser: one destination pixel in, one address word out.
// A pixel passes front-end, queue, divide and output registers before done_o;
// one word per cycle if busy is low; fully pipelined, one quotient bit per stage.
// Reset and every register write rerun the layout solve (one bit per cycle on its
// own divider, skipped on error); busy stays high meanwhile.
// The receiver cannot stall: each word is shown for exactly one cycle.
module letterbox_resize_addresser #(
  parameter int unsigned MAX_DIM = 8192
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lra_pkg::in_t  item_i,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  output logic          done_o,
  output lra_pkg::out_t res_o
);

  lra_pkg::lay_t    lay;
  logic             q_full, q_empty, push;
  lra_pkg::q_item_t f_item, b_item;

  lra_layout #(
    .MAX_DIM (MAX_DIM)
  ) u_layout (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .lay_o      (lay)
  );

  lra_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .item_i   (item_i),
    .lay_i    (lay),
    .q_full_i (q_full),
    .busy_o   (busy),
    .push_o   (push),
    .item_o   (f_item)
  );

  lra_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (f_item),
    .pop_i   (!q_empty),
    .full_o  (q_full),
    .empty_o (q_empty),
    .rdata_o (b_item)
  );

  lra_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (!q_empty),
    .item_i (b_item),
    .lay_i  (lay),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule

// ===== sv/lra_checker.sv =====
// Port-level checks for letterbox_resize_addresser, bound to the top level.
// Uses lra_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module lra_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          busy,
  input logic          cfg_we_i,
  input logic          done_o,
  input lra_pkg::out_t res_o
);

  // a write restarts the layout solve, so no pixel is taken next cycle
  `LRA_ASSERT_NXT(a_cfg_busy, cfg_we_i, busy)
  `LRA_ASSERT_IMP(a_err_clear, done_o && res_o.config_error, !res_o.is_padding && res_o.fit_width == 14'd0 && res_o.dst_byte_offset == 29'd0)
  `LRA_ASSERT_IMP(a_pad_zero, done_o && res_o.is_padding, res_o.src_col == 13'd0 && res_o.src_row == 13'd0 && res_o.src_byte_offset == 29'd0)
  `LRA_ASSERT_IMP(a_size_nz, done_o && !res_o.config_error, res_o.fit_width != 14'd0 && res_o.fit_height != 14'd0)

endmodule

bind letterbox_resize_addresser lra_checker u_lra_checker (.*);
